// File: design/vssp_pkg.sv
package vssp_pkg;

   // field and register widths
   localparam int TIME_W   = 40;
   localparam int BYTES_W  = 48;
   localparam int RATE_W   = 32;
   localparam int PERIOD_W = 32;
   localparam int AMT_W    = 49;
   localparam int PHASE_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;

   // internal datapath widths
   localparam int SPAN_W = TIME_W + 1;
   localparam int PROD_W = SPAN_W + RATE_W;
   localparam int FRAC_W = 16;
   localparam int DIFF_W = PROD_W + 2;
   localparam int CNT_W  = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BUFFERING_RATE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STREAMING_RATE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BUFFERING_DURATION = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STREAMING_PERIOD   = 2'd3;

   // connection phases
   localparam logic [PHASE_W-1:0] PHASE_CONNECTING = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_BUFFERING  = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_STREAMING  = 2'd2;

   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [BYTES_W-1:0] bytes_type;

endpackage

// File: design/video_stream_send_pacer.sv
// Send pacer for a video-like stream. Each request transfer carries the ticks
// since connect and the bytes sent so far; the response transfer gives the
// signed byte count to send now (zero or negative: send nothing) and the phase
// after the query. The first query moves the block from connecting to
// buffering, where the target is time * buffering_rate. A buffering query
// whose time reaches buffering_duration switches to streaming and keeps its
// byte count; the streaming target is that count plus the end of the current
// period times streaming_rate. Rates are unsigned Q16.16, the answer is
// truncated toward zero and saturated to 49 bits signed. One query is in work
// at a time. A buffering query runs a setup step, a bit-serial shift-add
// multiply by the rate, then one sum and one saturation step. A streaming
// query adds one step to form the span, and with a non-zero period also,
// ahead of that, a bit-serial restoring division for the period remainder.
// The next request is taken in the cycle after the previous response is
// loaded; a waiting response does not block the next query until that one
// finishes. The user must write registers only while idle; the block itself
// does not enforce it.
module video_stream_send_pacer (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [vssp_pkg::TIME_W-1:0]            req_elapsed_time,
   input  logic [vssp_pkg::BYTES_W-1:0]           req_bytes_sent_total,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [vssp_pkg::AMT_W-1:0]      rsp_send_amount,
   output logic [vssp_pkg::PHASE_W-1:0]           rsp_phase,
   // register write port
   input  logic                                   csr_write_en,
   input  logic [vssp_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [vssp_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int TIME_W   = vssp_pkg::TIME_W;
   localparam int BYTES_W  = vssp_pkg::BYTES_W;
   localparam int RATE_W   = vssp_pkg::RATE_W;
   localparam int PERIOD_W = vssp_pkg::PERIOD_W;
   localparam int AMT_W    = vssp_pkg::AMT_W;
   localparam int PHASE_W  = vssp_pkg::PHASE_W;
   localparam int SPAN_W   = vssp_pkg::SPAN_W;
   localparam int PROD_W   = vssp_pkg::PROD_W;
   localparam int FRAC_W   = vssp_pkg::FRAC_W;
   localparam int DIFF_W   = vssp_pkg::DIFF_W;
   localparam int CNT_W    = vssp_pkg::CNT_W;
   localparam int QUOT_W   = DIFF_W - FRAC_W;

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_SPAN = 3'd3;
   localparam logic [2:0] ST_MUL  = 3'd4;
   localparam logic [2:0] ST_SUM  = 3'd5;
   localparam logic [2:0] ST_SAT  = 3'd6;

   // configuration registers
   logic [RATE_W-1:0]   brate_ff;
   logic [RATE_W-1:0]   srate_ff;
   logic [TIME_W-1:0]   bdur_ff;
   logic [PERIOD_W-1:0] period_ff;

   // control state
   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   logic [BYTES_W-1:0]  babe_ff, babe_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath registers
   vssp_pkg::time_type  t_ff, t_in;
   vssp_pkg::bytes_type bytes_ff, bytes_in;
   logic [TIME_W-1:0]   e_ff, e_in;
   logic [TIME_W-1:0]   div_sh_ff, div_sh_in;
   logic [PERIOD_W-1:0] rem_ff, rem_in;
   logic signed [AMT_W-1:0] offs_ff, offs_in;
   logic [SPAN_W-1:0]   mcand_ff, mcand_in;
   logic [RATE_W-1:0]   mplier_ff, mplier_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [AMT_W-1:0] amt_ff, amt_in;
   logic [PHASE_W-1:0]  rsp_phase_ff, rsp_phase_in;

   // combinational helpers
   logic                req_xfer;
   logic                rsp_xfer;
   logic                rsp_free;
   logic [PERIOD_W:0]   div_trial;
   logic [SPAN_W:0]     mul_sum;
   logic [SPAN_W-1:0]   span;
   logic [BYTES_W-1:0]  kept;
   logic signed [DIFF_W-1:0] diff_tz;
   logic [QUOT_W-1:0]   quot;
   logic                quot_fits;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   // output register can take a new result
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_send_amount = amt_ff;
   assign rsp_phase       = rsp_phase_ff;

   // one restoring division step: shift in next dividend bit, try the period
   assign div_trial = {rem_ff, div_sh_ff[TIME_W-1]};

   // one shift-add step over the low multiplier bit
   assign mul_sum = {1'b0, prod_ff[PROD_W-1:RATE_W]}
                  + (mplier_ff[0] ? {1'b0, mcand_ff} : {(SPAN_W+1){1'b0}});

   // end of current period: e - (e mod p) + p, zero when period is zero
   assign span = (period_ff == '0) ? '0
               : ({1'b0, e_ff} - {{(SPAN_W-PERIOD_W){1'b0}}, rem_ff})
                 + {{(SPAN_W-PERIOD_W){1'b0}}, period_ff};

   // kept byte count only counts while streaming
   assign kept = (phase_ff == vssp_pkg::PHASE_STREAMING) ? babe_ff : '0;

   // truncate toward zero: bias negatives by all-ones fraction before shift
   assign diff_tz = diff_ff
                  + $signed({{(DIFF_W-FRAC_W){1'b0}}, {FRAC_W{diff_ff[DIFF_W-1]}}});
   assign quot    = diff_tz[DIFF_W-1:FRAC_W];
   assign quot_fits = (&quot[QUOT_W-1:AMT_W-1]) || !(|quot[QUOT_W-1:AMT_W-1]);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      babe_in      = babe_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      t_in         = t_ff;
      bytes_in     = bytes_ff;
      e_in         = e_ff;
      div_sh_in    = div_sh_ff;
      rem_in       = rem_ff;
      offs_in      = offs_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      diff_in      = diff_ff;
      amt_in       = amt_ff;
      rsp_phase_in = rsp_phase_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               t_in     = req_elapsed_time;
               bytes_in = req_bytes_sent_total;
               // phase moves on the query itself
               if (phase_ff == vssp_pkg::PHASE_BUFFERING) begin
                  babe_in = req_bytes_sent_total;
                  if (req_elapsed_time >= bdur_ff) begin
                     phase_in = vssp_pkg::PHASE_STREAMING;
                  end
               end else if (phase_ff != vssp_pkg::PHASE_STREAMING) begin
                  phase_in = vssp_pkg::PHASE_BUFFERING;
               end
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // streaming time, clamped at zero
            e_in      = (t_ff >= bdur_ff) ? (t_ff - bdur_ff) : '0;
            div_sh_in = (t_ff >= bdur_ff) ? (t_ff - bdur_ff) : '0;
            rem_in    = '0;
            offs_in   = $signed({1'b0, kept}) - $signed({1'b0, bytes_ff});
            prod_in   = '0;
            if (phase_ff == vssp_pkg::PHASE_BUFFERING) begin
               mcand_in  = {1'b0, t_ff};
               mplier_in = brate_ff;
               cnt_in    = CNT_W'(RATE_W - 1);
               state_in  = ST_MUL;
            end else if (period_ff != '0) begin
               cnt_in   = CNT_W'(TIME_W - 1);
               state_in = ST_DIV;
            end else begin
               state_in = ST_SPAN;
            end
         end
         ST_DIV: begin
            div_sh_in = {div_sh_ff[TIME_W-2:0], 1'b0};
            if (div_trial >= {1'b0, period_ff}) begin
               rem_in = PERIOD_W'(div_trial - {1'b0, period_ff});
            end else begin
               rem_in = div_trial[PERIOD_W-1:0];
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            mcand_in  = span;
            mplier_in = srate_ff;
            cnt_in    = CNT_W'(RATE_W - 1);
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            prod_in   = {mul_sum, prod_ff[RATE_W-1:1]};
            mplier_in = {1'b0, mplier_ff[RATE_W-1:1]};
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // target minus bytes, all in Q16.16
            diff_in = $signed({2'b00, prod_ff})
                    + $signed({{(DIFF_W-AMT_W-FRAC_W){offs_ff[AMT_W-1]}},
                               offs_ff, {FRAC_W{1'b0}}});
            state_in = ST_SAT;
         end
         ST_SAT: begin
            // wait here while the previous response still sits unclaimed
            if (rsp_free) begin
               if (quot_fits) begin
                  amt_in = quot[AMT_W-1:0];
               end else if (quot[QUOT_W-1]) begin
                  amt_in = {1'b1, {(AMT_W-1){1'b0}}};
               end else begin
                  amt_in = {1'b0, {(AMT_W-1){1'b1}}};
               end
               rsp_phase_in = phase_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         brate_ff  <= '0;
         srate_ff  <= '0;
         bdur_ff   <= '0;
         period_ff <= PERIOD_W'(1);
      end else if (csr_write_en) begin
         case (csr_index)
            vssp_pkg::REG_BUFFERING_RATE:     brate_ff  <= csr_wdata[RATE_W-1:0];
            vssp_pkg::REG_STREAMING_RATE:     srate_ff  <= csr_wdata[RATE_W-1:0];
            vssp_pkg::REG_BUFFERING_DURATION: bdur_ff   <= csr_wdata[TIME_W-1:0];
            vssp_pkg::REG_STREAMING_PERIOD:   period_ff <= csr_wdata[PERIOD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         phase_ff     <= vssp_pkg::PHASE_CONNECTING;
         babe_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         babe_ff      <= babe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      bytes_ff     <= bytes_in;
      e_ff         <= e_in;
      div_sh_ff    <= div_sh_in;
      rem_ff       <= rem_in;
      offs_ff      <= offs_in;
      mcand_ff     <= mcand_in;
      mplier_ff    <= mplier_in;
      prod_ff      <= prod_in;
      diff_ff      <= diff_in;
      amt_ff       <= amt_in;
      rsp_phase_ff <= rsp_phase_in;
   end

`ifndef SYNTHESIS
   // a delivered phase is always buffering or streaming
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_phase == vssp_pkg::PHASE_BUFFERING
                     || rsp_phase == vssp_pkg::PHASE_STREAMING))
      else $error("response phase is neither buffering nor streaming");

   // streaming is never left once entered
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == vssp_pkg::PHASE_STREAMING) |=> (phase_ff == vssp_pkg::PHASE_STREAMING))
      else $error("phase left streaming");

   // the divider only runs on a non-zero period while streaming
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (period_ff != '0
                                && phase_ff == vssp_pkg::PHASE_STREAMING))
      else $error("division started without a streaming period");

   // a stalled response is not overwritten
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(amt_ff) && $stable(rsp_phase_ff))
      else $error("pending response overwritten");
`endif

endmodule

// File: tb/vssp_result_monitor.sv
module vssp_result_monitor (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [vssp_pkg::TIME_W-1:0]          req_elapsed_time,
   input  logic [vssp_pkg::BYTES_W-1:0]         req_bytes_sent_total,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [vssp_pkg::AMT_W-1:0]    rsp_send_amount,
   input  logic [vssp_pkg::PHASE_W-1:0]         rsp_phase,
   input  logic                                 csr_write_en,
   input  logic [vssp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vssp_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output int                                   results_due,
   output int                                   mismatch_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIME_W   = vssp_pkg::TIME_W;
   localparam int BYTES_W  = vssp_pkg::BYTES_W;
   localparam int RATE_W   = vssp_pkg::RATE_W;
   localparam int PERIOD_W = vssp_pkg::PERIOD_W;
   localparam int AMT_W    = vssp_pkg::AMT_W;
   localparam int PHASE_W  = vssp_pkg::PHASE_W;

   localparam logic [127:0] SAT_POS = (128'd1 << 48) - 128'd1;
   localparam logic [127:0] SAT_NEG = 128'd1 << 48;

   typedef struct packed {
      logic signed [AMT_W-1:0] send_amount;
      logic [PHASE_W-1:0]      phase;
   } pace_result_type;

   pace_result_type due_results[$];
   int fail_count = 0;

   // shadow of the pacer registers and state
   logic [RATE_W-1:0]   buf_rate;
   logic [RATE_W-1:0]   strm_rate;
   logic [TIME_W-1:0]   buf_dur;
   logic [PERIOD_W-1:0] strm_period;
   logic [PHASE_W-1:0]  phase_q;
   logic [BYTES_W-1:0]  kept_bytes;

   always @(posedge clock) begin : watch
      pace_result_type  want;
      pace_result_type  got;
      logic [TIME_W-1:0]  t;
      logic [BYTES_W-1:0] b;
      logic [63:0]   excess;
      logic [63:0]   span;
      logic [127:0]  target;
      logic [127:0]  scaled_bytes;
      logic [127:0]  diff;
      logic [127:0]  mag;
      logic          neg;

      if (reset) begin
         buf_rate    = '0;
         strm_rate   = '0;
         buf_dur     = '0;
         strm_period = PERIOD_W'(1);
         phase_q     = vssp_pkg::PHASE_CONNECTING;
         kept_bytes  = '0;
         due_results.delete();
         results_due <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               vssp_pkg::REG_BUFFERING_RATE:     buf_rate    = csr_wdata[RATE_W-1:0];
               vssp_pkg::REG_STREAMING_RATE:     strm_rate   = csr_wdata[RATE_W-1:0];
               vssp_pkg::REG_BUFFERING_DURATION: buf_dur     = csr_wdata[TIME_W-1:0];
               vssp_pkg::REG_STREAMING_PERIOD:   strm_period = csr_wdata[PERIOD_W-1:0];
               default: ;
            endcase
         end

         // response transfer: compare with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               $error("response transfer with no query waiting: send_amount %0d phase %0d",
                      rsp_send_amount, rsp_phase);
               fail_count++;
            end else begin
               want = due_results.pop_front();
               got.send_amount = rsp_send_amount;
               got.phase       = rsp_phase;
               if (got.send_amount !== want.send_amount) begin
                  $error("send_amount: expected %0d, got %0d",
                         want.send_amount, got.send_amount);
                  fail_count++;
               end
               if (got.phase !== want.phase) begin
                  $error("phase: expected %0d, got %0d", want.phase, got.phase);
                  fail_count++;
               end
            end
         end

         // request transfer: advance the phase and work out the answer
         if (req_valid && !req_stall) begin
            t = req_elapsed_time;
            b = req_bytes_sent_total;
            if (phase_q == vssp_pkg::PHASE_BUFFERING) begin
               kept_bytes = b;
               if (t >= buf_dur)
                  phase_q = vssp_pkg::PHASE_STREAMING;
            end else if (phase_q != vssp_pkg::PHASE_STREAMING) begin
               // connecting, or an unused code
               phase_q = vssp_pkg::PHASE_BUFFERING;
            end

            if (phase_q == vssp_pkg::PHASE_BUFFERING) begin
               target = {88'd0, t} * {96'd0, buf_rate};
            end else begin
               // time before the end of buffering counts as zero
               excess = (t >= buf_dur) ? (64'(t) - 64'(buf_dur)) : 64'd0;
               if (strm_period == '0)
                  span = 64'd0;
               else
                  span = (excess / 64'(strm_period) + 64'd1) * 64'(strm_period);
               target = ({80'd0, kept_bytes} << 16) + ({64'd0, span} * {96'd0, strm_rate});
            end

            scaled_bytes = {80'd0, b} << 16;
            neg  = target < scaled_bytes;
            diff = neg ? (scaled_bytes - target) : (target - scaled_bytes);
            mag  = diff >> 16;
            if (!neg && mag > SAT_POS)
               mag = SAT_POS;
            if (neg && mag > SAT_NEG)
               mag = SAT_NEG;
            want.send_amount = neg ? -mag[AMT_W-1:0] : mag[AMT_W-1:0];
            want.phase       = phase_q;
            due_results.push_back(want);
         end
         results_due <= due_results.size();
      end
      mismatch_count <= fail_count;
   end

endmodule

// File: tb/tb_video_stream_send_pacer.sv
module tb_video_stream_send_pacer;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TIME_W     = vssp_pkg::TIME_W;
   localparam int BYTES_W    = vssp_pkg::BYTES_W;
   localparam int RATE_W     = vssp_pkg::RATE_W;
   localparam int PERIOD_W   = vssp_pkg::PERIOD_W;
   localparam int AMT_W      = vssp_pkg::AMT_W;
   localparam int PHASE_W    = vssp_pkg::PHASE_W;
   localparam int CSR_IDX_W  = vssp_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = vssp_pkg::CSR_DATA_W;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam logic [TIME_W-1:0]   TIME_MAX   = '1;
   localparam logic [BYTES_W-1:0]  BYTES_MAX  = '1;
   localparam logic [RATE_W-1:0]   RATE_MAX   = '1;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
   localparam logic [RATE_W-1:0]   RATE_ONE   = 32'h0001_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid            = 1'b0;
   logic                        req_stall;
   logic [TIME_W-1:0]           req_elapsed_time     = '0;
   logic [BYTES_W-1:0]          req_bytes_sent_total = '0;
   logic                        rsp_valid;
   logic                        rsp_stall            = 1'b0;
   logic signed [AMT_W-1:0]     rsp_send_amount;
   logic [PHASE_W-1:0]          rsp_phase;
   logic                        csr_write_en         = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index            = '0;
   logic [CSR_DATA_W-1:0]       csr_wdata            = '0;

   int results_due;
   int mismatch_count;
   int cycle_count = 0;

   // sender pacing and the tb copy of the timing registers
   int                  burst_left = 0;
   logic [TIME_W-1:0]   last_time  = '0;
   logic [BYTES_W-1:0]  last_bytes = '0;
   logic [TIME_W-1:0]   cur_dur    = '0;
   logic [PERIOD_W-1:0] cur_period = PERIOD_W'(1);

   // receiver stall pattern
   int stall_kind = 0;
   int stall_left = 0;

   always #1 clock = ~clock;

   video_stream_send_pacer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_elapsed_time     (req_elapsed_time),
      .req_bytes_sent_total (req_bytes_sent_total),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_send_amount      (rsp_send_amount),
      .rsp_phase            (rsp_phase),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   vssp_result_monitor monitor (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_elapsed_time     (req_elapsed_time),
      .req_bytes_sent_total (req_bytes_sent_total),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_send_amount      (rsp_send_amount),
      .rsp_phase            (rsp_phase),
      .csr_write_en         (csr_write_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .results_due          (results_due),
      .mismatch_count       (mismatch_count)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver: solid stall runs, random stalls, and long free stretches
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_kind = $urandom_range(0, 9);
         stall_left = (stall_kind == 0) ? 200 : $urandom_range(1, 24);
      end
      stall_left--;
      case (stall_kind)
         0:       rsp_stall <= 1'b0;
         1, 2, 3: rsp_stall <= 1'b1;
         default: rsp_stall <= ($urandom_range(0, 2) == 0);
      endcase
   end

   // register write, with the enable dropped again so it never toggles twice in a step
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      if (idx == vssp_pkg::REG_BUFFERING_DURATION)
         cur_dur = value[TIME_W-1:0];
      if (idx == vssp_pkg::REG_STREAMING_PERIOD)
         cur_period = value[PERIOD_W-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // end of a transfer: either stay in the burst or go quiet for a while
   task automatic sender_pause();
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // one query, held until its request transfer
   task automatic send_query(input logic [TIME_W-1:0] t, input logic [BYTES_W-1:0] b);
      req_valid            <= 1'b1;
      req_elapsed_time     <= t;
      req_bytes_sent_total <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      last_time  = t;
      last_bytes = b;
      sender_pause();
   endtask

   // stop sending until every answer is back; the wait after lets the count catch up
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // mostly steadily growing time and byte counts, some jumps, some going back
   task automatic random_query(input bit streaming);
      longint            tt;
      logic [63:0]       bb;
      longint            reach;
      int                pick;
      logic [TIME_W-1:0] t_cap;

      if (!streaming)
         reach = 2000;
      else if (cur_period == '0 || cur_period > 65536)
         reach = 65536;
      else
         reach = longint'(cur_period);
      // buffering must stay below its end time, which is the top of the range here
      t_cap = streaming ? TIME_MAX : TIME_MAX - 40'd1;

      pick = $urandom_range(0, 99);
      if (pick < 55)
         tt = longint'(last_time) + longint'($urandom_range(0, 32'(2 * reach)));
      else if (pick < 70)
         tt = longint'({$urandom, $urandom} & 64'(TIME_MAX));
      else if (pick < 80)
         tt = longint'(last_time) - longint'($urandom_range(0, 1000));
      else if (pick < 90)
         tt = longint'($urandom_range(0, 255));
      else
         tt = (streaming ? longint'(cur_dur) : longint'(t_cap)) - reach
              + longint'($urandom_range(0, 32'(4 * reach)));
      if (tt < 0)
         tt = 0;
      if (tt > longint'(t_cap))
         tt = longint'(t_cap);

      pick = $urandom_range(0, 99);
      if (pick < 50)
         bb = 64'(last_bytes) + 64'($urandom_range(0, 65536));
      else if (pick < 75)
         bb = {$urandom, $urandom};
      else if (pick < 90)
         bb = 64'($urandom_range(0, 1023));
      else
         bb = $urandom_range(0, 1) ? 64'(BYTES_MAX) : 64'd0;

      send_query(tt[TIME_W-1:0], bb[BYTES_W-1:0]);
   endtask

   task automatic random_run(input int count, input bit streaming);
      repeat (count) begin
         random_query(streaming);
         // now and then wait for the pipe to empty before going on
         if ($urandom_range(0, 79) == 0)
            drain_results();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // buffering lasts to the top of the time range
      write_reg(vssp_pkg::REG_BUFFERING_DURATION, CSR_DATA_W'(TIME_MAX));

      // first query at the end time still only enters buffering
      send_query(TIME_MAX, '0);
      send_query('0, BYTES_MAX);
      send_query(TIME_MAX - 40'd1, '0);
      drain_results();

      // full rate: the target overflows and saturates high
      write_reg(vssp_pkg::REG_BUFFERING_RATE, CSR_DATA_W'(RATE_MAX));
      send_query(TIME_MAX - 40'd1, '0);
      send_query(40'd1, '0);
      send_query(TIME_MAX - 40'd1, BYTES_MAX);
      random_run(100, 1'b0);

      drain_results();
      write_reg(vssp_pkg::REG_BUFFERING_RATE, CSR_DATA_W'(RATE_ONE));
      last_time = '0;
      random_run(100, 1'b0);

      drain_results();
      write_reg(vssp_pkg::REG_BUFFERING_RATE, CSR_DATA_W'($urandom));
      last_time = '0;
      random_run(100, 1'b0);

      // leave buffering with a query exactly at the end time
      drain_results();
      write_reg(vssp_pkg::REG_BUFFERING_DURATION,
                CSR_DATA_W'(5000 + $urandom_range(0, 5000)));
      write_reg(vssp_pkg::REG_STREAMING_RATE, CSR_DATA_W'(RATE_ONE));
      write_reg(vssp_pkg::REG_STREAMING_PERIOD, CSR_DATA_W'(100));
      send_query(cur_dur, last_bytes);
      // streaming query before the end of buffering: elapsed clamps to zero
      send_query(cur_dur - 40'd50, last_bytes + 48'd10);
      send_query(cur_dur + 40'd99, last_bytes + 48'd20);
      send_query(cur_dur + 40'd100, last_bytes + 48'd30);
      random_run(100, 1'b1);

      // extremes: full rate, longest period, no buffering time
      drain_results();
      write_reg(vssp_pkg::REG_STREAMING_RATE, CSR_DATA_W'(RATE_MAX));
      write_reg(vssp_pkg::REG_STREAMING_PERIOD, CSR_DATA_W'(PERIOD_MAX));
      write_reg(vssp_pkg::REG_BUFFERING_DURATION, '0);
      send_query(TIME_MAX, '0);
      send_query('0, BYTES_MAX);
      random_run(100, 1'b1);

      drain_results();
      write_reg(vssp_pkg::REG_STREAMING_RATE, '0);
      write_reg(vssp_pkg::REG_STREAMING_PERIOD, CSR_DATA_W'(1));
      random_run(80, 1'b1);

      // zero period: the target is just the kept count
      drain_results();
      write_reg(vssp_pkg::REG_STREAMING_RATE, CSR_DATA_W'($urandom));
      write_reg(vssp_pkg::REG_STREAMING_PERIOD, '0);
      send_query(cur_dur, '0);
      send_query(cur_dur + 40'd1000, BYTES_MAX);
      random_run(60, 1'b1);

      // end time at the top: nearly every query clamps
      drain_results();
      write_reg(vssp_pkg::REG_BUFFERING_DURATION, CSR_DATA_W'(TIME_MAX));
      write_reg(vssp_pkg::REG_STREAMING_PERIOD, CSR_DATA_W'($urandom_range(1, 1000)));
      random_run(60, 1'b1);

      drain_results();
      write_reg(vssp_pkg::REG_BUFFERING_RATE, CSR_DATA_W'($urandom));
      write_reg(vssp_pkg::REG_STREAMING_RATE, CSR_DATA_W'($urandom));
      write_reg(vssp_pkg::REG_STREAMING_PERIOD, CSR_DATA_W'($urandom_range(1, 5000)));
      write_reg(vssp_pkg::REG_BUFFERING_DURATION,
                CSR_DATA_W'($urandom_range(0, 1 << 20)));
      random_run(150, 1'b1);

      drain_results();
      write_reg(vssp_pkg::REG_STREAMING_RATE, CSR_DATA_W'($urandom));
      write_reg(vssp_pkg::REG_STREAMING_PERIOD, CSR_DATA_W'($urandom | 1));
      write_reg(vssp_pkg::REG_BUFFERING_DURATION, CSR_DATA_W'({$urandom, $urandom}));
      random_run(100, 1'b1);

      drain_results();
      // room for a late or stray response transfer
      repeat (100) @(posedge clock);

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
